// ===== rtl/sine_voice_with_tail_off_assert.svh =====
// Assertion shorthands for the voice: sampled on clk, off while arst_n is low.
`ifndef SINE_VOICE_WITH_TAIL_OFF_ASSERT_SVH
`define SINE_VOICE_WITH_TAIL_OFF_ASSERT_SVH

// Plain property, checked at every rising edge of clk.
`define SVTO_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SVTO_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SVTO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/svto_pkg.sv =====
`timescale 1ns / 1ps

package svto_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	// request codes
	localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
	localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
	localparam logic [1:0] FUNC_TICK     = 2'd2;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HZ    = 2'd1;

	localparam logic [31:0] HZ_RESET   = 32'd97391;
	localparam logic [15:0] DECAY_Q16  = 16'd64881;
	localparam logic [16:0] STOP_LEVEL = 17'd327;
	localparam logic [16:0] TAIL_ONE   = 17'd65536;
	localparam logic [14:0] SINE_MAX   = 15'd32767;

	// quarter-wave sine polynomial, Horner form in Q30
	typedef logic [31:0] horner_t [0:3];
	localparam logic [31:0] HORNER_SEED = 32'd172272;
	localparam horner_t HORNER_C = '{32'd5026995, 32'd85569306, 32'd693598668,
		32'd1686629713};

	// note frequency ROM, Q16 Hz
	typedef logic [29:0] freq_t;
	typedef freq_t note_rom_t [0:127];
	typedef logic [31:0] octave_t [0:11];
	localparam octave_t TOP_OCTAVE = '{
		32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
		32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
		32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353};

	function automatic note_rom_t build_note_rom();
		note_rom_t rom;
		logic [63:0] v;
		int idx;
		int sh;
		rom = '{default: '0};
		for (int oct = 0; oct < 11; oct++) begin
			for (int pc = 0; pc < 12; pc++) begin
				idx = oct * 12 + pc;
				sh = 10 - oct;
				if (sh == 0)
					v = 64'(TOP_OCTAVE[pc]);
				else
					v = (64'(TOP_OCTAVE[pc]) + (64'd1 << (sh - 1))) >> sh;
				if (idx < 128)
					rom[idx] = v[29:0];
			end
		end
		return rom;
	endfunction

	localparam note_rom_t NOTE_FREQ_Q16 = build_note_rom();

	// datapath operations
	typedef enum logic [3:0] {
		OP_IDLE, OP_LATCH, OP_FREQ, OP_NOTE_ON, OP_NOTE_OFF, OP_X, OP_X2,
		OP_HSUB, OP_MAG, OP_MSEL, OP_OUT, OP_DUPD
	} svto_op_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_FREQ, MUL_XX, MUL_AX2, MUL_AX, MUL_LVL, MUL_TAIL, MUL_DECAY
	} svto_mul_t;

	typedef struct packed {
		svto_op_t  op;
		logic      mul_en;
		svto_mul_t mul_sel;
		logic [1:0] step;
		logic      load_out;
	} svto_cmd_t;

	typedef struct packed {
		logic active;
		logic tailing;
	} svto_stat_t;

endpackage

// ===== rtl/svto_dp.sv =====
`timescale 1ns / 1ps
`include "sine_voice_with_tail_off_assert.svh"

module svto_dp #(
	parameter int SINE_TABLE_BITS = svto_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = svto_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [svto_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [31:0]                          cfg_data,
	input  logic [6:0]                           note,
	input  logic                                 allow_tail_off,
	input  svto_pkg::svto_cmd_t                  cmd,
	output svto_pkg::svto_stat_t                 stat,
	output logic signed [SAMPLE_BITS-1:0]        sample,
	output logic                                 active,
	output logic                                 tailing
);

	localparam int QBITS = SINE_TABLE_BITS - 2;
	localparam int SHIFT = 32 - SAMPLE_BITS;
	localparam logic [32:0] OUT_ROUND = 33'd1 << (SHIFT - 1);
	localparam logic [SAMPLE_BITS-1:0] OUT_LIM = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [QBITS:0] QUARTER = {1'b1, {QBITS{1'b0}}};

	logic [15:0] level_q;
	logic [31:0] hz_q;
	logic [31:0] phase_q;
	logic [31:0] inc_q;
	logic [16:0] tail_q;

	logic [6:0]  note_q;
	logic        allow_q;
	svto_pkg::freq_t freq_q;
	logic [30:0] x_q;
	logic [30:0] x2_q;
	logic        neg_q;
	logic [31:0] acc_q;
	logic [63:0] prod_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic        active_q;
	logic        tailing_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [QBITS-1:0] pos;
	logic [QBITS:0]   fold;
	logic [32:0] mag_sum;
	logic [14:0] mag_sat;
	logic [47:0] tail_sum;
	logic [32:0] out_sum;
	logic [32:0] out_shift;
	logic [SAMPLE_BITS-1:0] out_sat;
	logic [32:0] dec_sum;
	logic [16:0] dec_t;

	always_comb begin
		unique case (cmd.mul_sel)
			svto_pkg::MUL_FREQ: begin
				mul_a = 32'(freq_q);
				mul_b = hz_q;
			end
			svto_pkg::MUL_XX: begin
				mul_a = 32'(x_q);
				mul_b = 32'(x_q);
			end
			svto_pkg::MUL_AX2: begin
				mul_a = acc_q;
				mul_b = 32'(x2_q);
			end
			svto_pkg::MUL_AX: begin
				mul_a = acc_q;
				mul_b = 32'(x_q);
			end
			svto_pkg::MUL_LVL: begin
				mul_a = acc_q;
				mul_b = 32'(level_q);
			end
			svto_pkg::MUL_TAIL: begin
				mul_a = prod_q[31:0];
				mul_b = 32'(tail_q);
			end
			svto_pkg::MUL_DECAY: begin
				mul_a = 32'(tail_q);
				mul_b = 32'(svto_pkg::DECAY_Q16);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// fold the phase onto the quarter wave
	assign idx  = phase_q[31 -: SINE_TABLE_BITS];
	assign pos  = idx[QBITS-1:0];
	assign fold = idx[QBITS] ? (QUARTER - {1'b0, pos}) : {1'b0, pos};

	assign mag_sum = {1'b0, prod_q[61:30]} + 33'd16384;
	assign mag_sat = (mag_sum[32:15] > 18'(svto_pkg::SINE_MAX)) ? svto_pkg::SINE_MAX :
		mag_sum[29:15];

	assign tail_sum = prod_q[47:0] + 48'd32768;

	assign out_sum   = {1'b0, acc_q} + OUT_ROUND;
	assign out_shift = out_sum >> SHIFT;
	assign out_sat   = (out_shift > 33'(OUT_LIM)) ? OUT_LIM : out_shift[SAMPLE_BITS-1:0];

	assign dec_sum = prod_q[32:0] + 33'd32768;
	assign dec_t   = dec_sum[32:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			hz_q    <= svto_pkg::HZ_RESET;
			phase_q <= '0;
			inc_q   <= '0;
			tail_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					svto_pkg::CFG_LEVEL: level_q <= cfg_data[15:0];
					svto_pkg::CFG_HZ:    hz_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (cmd.op)
				svto_pkg::OP_NOTE_ON: begin
					phase_q <= '0;
					tail_q  <= '0;
					inc_q   <= prod_q[47:16];
				end
				svto_pkg::OP_NOTE_OFF: begin
					if (allow_q) begin
						if (inc_q != '0 && tail_q == '0)
							tail_q <= svto_pkg::TAIL_ONE;
					end else begin
						inc_q  <= '0;
						tail_q <= '0;
					end
				end
				svto_pkg::OP_OUT: phase_q <= phase_q + inc_q;
				svto_pkg::OP_DUPD: begin
					if (dec_t <= svto_pkg::STOP_LEVEL) begin
						tail_q <= '0;
						inc_q  <= '0;
					end else begin
						tail_q <= dec_t;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= mul_p;
		if (cmd.load_out) begin
			sample_q  <= res_q;
			active_q  <= (inc_q != '0);
			tailing_q <= (tail_q != '0);
		end
		unique case (cmd.op)
			svto_pkg::OP_LATCH: begin
				note_q  <= note;
				allow_q <= allow_tail_off;
				res_q   <= '0;
			end
			svto_pkg::OP_FREQ: freq_q <= svto_pkg::NOTE_FREQ_Q16[note_q];
			svto_pkg::OP_X: begin
				x_q   <= {fold, {(30-QBITS){1'b0}}};
				neg_q <= idx[SINE_TABLE_BITS-1];
			end
			svto_pkg::OP_X2: begin
				x2_q  <= prod_q[60:30];
				acc_q <= svto_pkg::HORNER_SEED;
			end
			svto_pkg::OP_HSUB: acc_q <= svto_pkg::HORNER_C[cmd.step] - prod_q[61:30];
			svto_pkg::OP_MAG:  acc_q <= 32'(mag_sat);
			svto_pkg::OP_MSEL: acc_q <= (tail_q != '0) ? tail_sum[47:16] : prod_q[31:0];
			svto_pkg::OP_OUT:  res_q <= neg_q ? (~out_sat + 1'b1) : out_sat;
			default: ;
		endcase
	end

	assign stat.active  = (inc_q != '0);
	assign stat.tailing = (tail_q != '0);
	assign sample  = sample_q;
	assign active  = active_q;
	assign tailing = tailing_q;

	`SVTO_ASSERT_IMPL(a_tail_needs_voice, tail_q != '0, inc_q != '0, "tail runs on a silent voice")
	`SVTO_ASSERT(a_tail_range, tail_q <= svto_pkg::TAIL_ONE, "tail above unity")
	`SVTO_ASSERT_NEXT(a_decay_drops, cmd.op == svto_pkg::OP_DUPD, tail_q < $past(tail_q), "no decay")

endmodule

// ===== rtl/svto_ctrl.sv =====
`timescale 1ns / 1ps
`include "sine_voice_with_tail_off_assert.svh"

module svto_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  svto_pkg::svto_stat_t stat,
	output svto_pkg::svto_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_FREQ, S_FMUL, S_NOTE_ON, S_NOTE_OFF, S_X, S_SQ, S_X2,
		S_HMUL, S_HSUB, S_SMUL, S_MAG, S_LMUL, S_TMUL, S_MSEL, S_OUT,
		S_DMUL, S_DUPD, S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] step_q;
	logic       out_valid_q;

	always_comb begin
		cmd.op       = svto_pkg::OP_IDLE;
		cmd.mul_en   = 1'b0;
		cmd.mul_sel  = svto_pkg::MUL_FREQ;
		cmd.step     = step_q;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE:     if (in_valid) cmd.op = svto_pkg::OP_LATCH;
			S_FREQ:     cmd.op = svto_pkg::OP_FREQ;
			S_FMUL:     cmd.mul_en = 1'b1;
			S_NOTE_ON:  cmd.op = svto_pkg::OP_NOTE_ON;
			S_NOTE_OFF: cmd.op = svto_pkg::OP_NOTE_OFF;
			S_X:        cmd.op = svto_pkg::OP_X;
			S_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = svto_pkg::MUL_XX;
			end
			S_X2:       cmd.op = svto_pkg::OP_X2;
			S_HMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = svto_pkg::MUL_AX2;
			end
			S_HSUB:     cmd.op = svto_pkg::OP_HSUB;
			S_SMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = svto_pkg::MUL_AX;
			end
			S_MAG:      cmd.op = svto_pkg::OP_MAG;
			S_LMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = svto_pkg::MUL_LVL;
			end
			S_TMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = svto_pkg::MUL_TAIL;
			end
			S_MSEL:     cmd.op = svto_pkg::OP_MSEL;
			S_OUT:      cmd.op = svto_pkg::OP_OUT;
			S_DMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = svto_pkg::MUL_DECAY;
			end
			S_DUPD:     cmd.op = svto_pkg::OP_DUPD;
			S_DONE:     cmd.load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						priority case (func)
							svto_pkg::FUNC_NOTE_ON:  state_q <= S_FREQ;
							svto_pkg::FUNC_NOTE_OFF: state_q <= S_NOTE_OFF;
							svto_pkg::FUNC_TICK:     state_q <= stat.active ? S_X : S_DONE;
							default:                 state_q <= S_DONE;
						endcase
					end
				end
				S_FREQ:     state_q <= S_FMUL;
				S_FMUL:     state_q <= S_NOTE_ON;
				S_NOTE_ON:  state_q <= S_DONE;
				S_NOTE_OFF: state_q <= S_DONE;
				S_X:        state_q <= S_SQ;
				S_SQ:       state_q <= S_X2;
				S_X2: begin
					step_q  <= '0;
					state_q <= S_HMUL;
				end
				S_HMUL:     state_q <= S_HSUB;
				S_HSUB: begin
					step_q  <= step_q + 2'd1;
					state_q <= (step_q == 2'd3) ? S_SMUL : S_HMUL;
				end
				S_SMUL:     state_q <= S_MAG;
				S_MAG:      state_q <= S_LMUL;
				S_LMUL:     state_q <= stat.tailing ? S_TMUL : S_MSEL;
				S_TMUL:     state_q <= S_MSEL;
				S_MSEL:     state_q <= S_OUT;
				S_OUT:      state_q <= stat.tailing ? S_DMUL : S_DONE;
				S_DMUL:     state_q <= S_DUPD;
				S_DUPD:     state_q <= S_DONE;
				S_DONE:     if (cmd.load_out) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`SVTO_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
	`SVTO_ASSERT_IMPL(a_load_free, cmd.load_out, !out_valid || out_ready, "result overwritten")

endmodule

// ===== rtl/sine_voice_with_tail_off.sv =====
`timescale 1ns / 1ps
// Requests are taken one at a time: in_ready is high only while the sequencer is idle, and the
//   single shared 32x32 multiplier is stepped through the sine polynomial for each tick.
// Reset (arst_n low, asynchronous): voice silent, phase and tail zero, level 0,
//   hz_to_increment 97391, no result pending; no clearing pass is needed.
module sine_voice_with_tail_off #(
	parameter int SINE_TABLE_BITS = svto_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = svto_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes: level at index 0, hz_to_increment at index 1
	input  logic                             cfg_we,
	input  logic [svto_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data,
	// request channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       func,
	input  logic [6:0]                       note,
	input  logic                             allow_tail_off,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [SAMPLE_BITS-1:0]    sample,
	output logic                             active,
	output logic                             tailing
);

	// Commands flow from the sequencer to the datapath; status (voice sounding,
	// tail running) flows back to steer the branch points of the sequence.
	svto_pkg::svto_cmd_t  cmd;
	svto_pkg::svto_stat_t stat;

	// Sequencer: take one request at a time, step the multiplier through
	// note frequency scaling, the quarter-wave Horner evaluation, the gain and
	// tail products and the tail decay, then hand the result to the output
	// register. A waiting result stalls the next pass in its done state.
	svto_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: configuration and voice registers, note ROM, the shared
	// multiplier with its product register, rounding and saturation, and the
	// output register that holds a result until it is taken.
	svto_dp #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.note           (note),
		.allow_tail_off (allow_tail_off),
		.cmd            (cmd),
		.stat           (stat),
		.sample         (sample),
		.active         (active),
		.tailing        (tailing)
	);

endmodule
